// ===== design/rsfc_pkg.sv =====
// Shared types, constants and frame-mapping functions for the RGB LED
// shift-frame controller. No dependencies; imported by every module.
`default_nettype none

package rsfc_pkg;

  localparam int FRAME_LEN = 36;
  localparam int FRAME_LAST = FRAME_LEN - 1;
  localparam int CNT_W = $clog2(FRAME_LEN);

  localparam logic [7:0] PWM_OFF = 8'd255;
  localparam logic [7:0] POWER_MAX = 8'd100;
  localparam logic [7:0] POWER_RESET = 8'd100;

  // Swinger LED, single-bit LEDs and the IR LED
  localparam logic [3:0] LED_SWINGER = 4'd6;
  localparam logic [3:0] LED_MONO_A = 4'd7;
  localparam logic [3:0] LED_MONO_B = 4'd8;
  localparam logic [3:0] LED_IR = 4'd9;
  localparam int MONO_A_BIT = 15;
  localparam int MONO_B_BIT = 17;

  localparam logic [3:0] NUM_RGB_LEDS = 4'd7;
  localparam logic [3:0] NUM_COLORS = 4'd8;
  localparam logic [2:0] BAR_MAX = 3'd6;
  localparam logic [2:0] BAR_LAST_LED = 3'd5;
  localparam logic [3:0] COMET_TAIL = 4'd4;

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_BAR   = 2'd1,
    KIND_PUSH  = 2'd2,
    KIND_CLEAR = 2'd3
  } cmd_kind_e;

  // Position of each color channel (row) of each LED (column) in the frame
  localparam logic [4:0] POS_TABLE [3][8] = '{
    '{5'd0, 5'd3, 5'd6, 5'd11, 5'd12, 5'd23, 5'd27, 5'd20},
    '{5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd17, 5'd26, 5'd20},
    '{5'd2, 5'd5, 5'd15, 5'd9, 5'd22, 5'd16, 5'd25, 5'd20}
  };

  // Work handed from the command front end to the serializer
  typedef struct packed {
    logic                 is_shift;
    logic [FRAME_LEN-1:0] frame;
    logic [7:0]           pwm;
    logic                 drv;
    logic                 ir;
    logic                 swg;
  } job_t;

  typedef struct packed {
    logic       shift_valid;
    logic       serial_data;
    logic       latch_pulse;
    logic       last;
    logic [7:0] pwm_compare;
    logic       driver_enable;
    logic       ir_led;
    logic       swinger;
  } result_t;

  function automatic logic [CNT_W-1:0] frame_idx(logic [1:0] ch, logic [2:0] led);
    return CNT_W'(FRAME_LAST - int'(POS_TABLE[ch][led]));
  endfunction

  // Color code to {B,G,R} enables
  function automatic logic [2:0] rgb_mask(logic [2:0] color);
    logic [2:0] m;
    unique case (color)
      3'd0: m = 3'b000;
      3'd1: m = 3'b001;
      3'd2: m = 3'b010;
      3'd3: m = 3'b100;
      3'd4: m = 3'b011;
      3'd5: m = 3'b101;
      3'd6: m = 3'b110;
      default: m = 3'b111;
    endcase
    return m;
  endfunction

  function automatic logic [FRAME_LEN-1:0] put_rgb(logic [FRAME_LEN-1:0] frame,
                                                   logic [2:0] led, logic [2:0] color);
    logic [FRAME_LEN-1:0] f;
    logic [2:0] m;
    f = frame;
    m = rgb_mask(color);
    for (int ch = 0; ch < 3; ch++) begin
      f[frame_idx(2'(ch), led)] = m[ch];
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== design/rsfc_front.sv =====
// Command front end: accepts commands, updates the frame and pin state,
// and queues one job per command. Depends on rsfc_pkg.
`default_nettype none

module rsfc_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           kind_i,
  input  wire logic [3:0]           led_number_i,
  input  wire logic [3:0]           color_i,
  input  wire logic                 reverse_i,
  input  wire logic                 comet_i,
  output rsfc_pkg::job_t            job_o
);
  import rsfc_pkg::*;

  logic [FRAME_LEN-1:0] frame_q, frame_d;
  logic                 ir_q, ir_d;
  logic                 swg_q, swg_d;
  logic [7:0]           cmp_q, cmp_d;
  logic                 drv_q, drv_d;
  logic [7:0]           power_q, power_d;

  logic [FRAME_LEN-1:0] bar_frame;
  logic [2:0]           bar_len;
  logic                 color_on;
  logic                 color_rgb;
  logic                 is_shift;

  assign color_on  = (color_i != 4'd0);
  assign color_rgb = (color_i < NUM_COLORS);
  assign bar_len   = (led_number_i > 4'(BAR_MAX)) ? BAR_MAX : led_number_i[2:0];

  // Bar: clear LEDs 0..5, then light the selected steps
  always_comb begin
    logic [2:0] step;
    logic       lit;
    bar_frame = frame_q;
    for (int j = 0; j <= int'(BAR_LAST_LED); j++) begin
      bar_frame = put_rgb(bar_frame, 3'(j), 3'd0);
    end
    for (int j = 0; j <= int'(BAR_LAST_LED); j++) begin
      step = reverse_i ? (BAR_LAST_LED - 3'(j)) : 3'(j);
      lit  = (step < bar_len) &&
             (!comet_i || ({1'b0, bar_len} <= COMET_TAIL) ||
              (({1'b0, step} + COMET_TAIL) > {1'b0, bar_len}));
      if (lit && color_rgb) begin
        bar_frame = put_rgb(bar_frame, 3'(j), color_i[2:0]);
      end
    end
  end

  always_comb begin
    frame_d  = frame_q;
    ir_d     = ir_q;
    swg_d    = swg_q;
    cmp_d    = cmp_q;
    drv_d    = drv_q;
    power_d  = cfg_we_i ? cfg_wdata_i : power_q;
    is_shift = 1'b0;
    if (accept_i) begin
      unique case (cmd_kind_e'(kind_i))
        KIND_SET: begin
          if (led_number_i < NUM_RGB_LEDS) begin
            if (color_rgb) begin
              frame_d = put_rgb(frame_q, led_number_i[2:0], color_i[2:0]);
            end
            if (led_number_i == LED_SWINGER) begin
              swg_d = color_on;
            end
          end else if (led_number_i == LED_MONO_A) begin
            frame_d[MONO_A_BIT] = color_on;
          end else if (led_number_i == LED_MONO_B) begin
            frame_d[MONO_B_BIT] = color_on;
          end else if (led_number_i == LED_IR) begin
            ir_d = color_on;
          end
        end
        KIND_BAR, KIND_PUSH: begin
          is_shift = 1'b1;
          if (cmd_kind_e'(kind_i) == KIND_BAR) begin
            frame_d = bar_frame;
          end
          // Restore PWM when the driver was switched off
          if (cmp_q == PWM_OFF) begin
            drv_d = 1'b1;
            cmp_d = PWM_OFF - ((power_q > POWER_MAX) ? POWER_MAX : power_q);
          end
        end
        KIND_CLEAR: begin
          frame_d = '0;
          cmp_d   = PWM_OFF;
          drv_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    job_o.is_shift = is_shift;
    job_o.frame    = frame_d;
    job_o.pwm      = cmp_d;
    job_o.drv      = drv_d;
    job_o.ir       = ir_d;
    job_o.swg      = swg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      ir_q    <= 1'b0;
      swg_q   <= 1'b0;
      cmp_q   <= '0;
      drv_q   <= 1'b1;
      power_q <= POWER_RESET;
    end else begin
      frame_q <= frame_d;
      ir_q    <= ir_d;
      swg_q   <= swg_d;
      cmp_q   <= cmp_d;
      drv_q   <= drv_d;
      power_q <= power_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rsfc_job_fifo.sv =====
// Short job queue between the command front end and the serializer.
// Depends on rsfc_pkg for the job type and depth.
`default_nettype none

module rsfc_job_fifo (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_en_i,
  input  wire rsfc_pkg::job_t wr_data_i,
  output logic          full_o,
  input  wire logic     rd_en_i,
  output rsfc_pkg::job_t rd_data_o,
  output logic          empty_o
);
  import rsfc_pkg::*;

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_PTR_W:0]   count_q;

  assign full_o    = (count_q == (JOB_PTR_W + 1)'(JOB_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rsfc_back.sv =====
// Serializer back end: turns queued jobs into result items, one per cycle
// while results are taken, through an output register. Depends on rsfc_pkg.
`default_nettype none

module rsfc_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rsfc_pkg::job_t job_i,
  input  wire logic      job_empty_i,
  output logic           job_pop_o,
  input  wire logic      res_pop_i,
  output logic           res_valid_o,
  output rsfc_pkg::result_t res_o
);
  import rsfc_pkg::*;

  logic [CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic             valid_q, valid_d;
  result_t          res_q, res_d;
  logic             load;
  logic             final_bit;

  assign load      = !job_empty_i && (!valid_q || res_pop_i);
  assign final_bit = (bit_cnt_q == CNT_W'(FRAME_LAST));
  assign job_pop_o = load && (!job_i.is_shift || final_bit);

  always_comb begin
    res_d.shift_valid   = job_i.is_shift;
    res_d.serial_data   = job_i.is_shift && job_i.frame[bit_cnt_q];
    res_d.latch_pulse   = job_i.is_shift && final_bit;
    res_d.last          = !job_i.is_shift || final_bit;
    res_d.pwm_compare   = job_i.pwm;
    res_d.driver_enable = job_i.drv;
    res_d.ir_led        = job_i.ir;
    res_d.swinger       = job_i.swg;

    bit_cnt_d = bit_cnt_q;
    if (load && job_i.is_shift) begin
      bit_cnt_d = final_bit ? '0 : bit_cnt_q + 1'b1;
    end

    // Hold the result until it is taken, refill in the same cycle
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (res_pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      valid_q   <= valid_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/rgb_led_shift_frame_controller.sv =====
// Top level of the RGB LED shift-frame controller: command front end,
// job queue and serializer. Depends on rsfc_pkg, rsfc_front, rsfc_job_fifo, rsfc_back.
//
//   channel   direction  handshake            payload
//   command   in         push / full          kind, led_number, color, reverse, comet
//   result    out        pop / empty          shift_valid .. swinger
//   config    in         cfg_we_i             cfg_wdata_i (power level)
//
// Set and clear give one result; bar and push give 36 results, one per cycle
// while the result side pops every cycle, paced by the serializer bit counter.
// The front end takes a command per cycle until the two-entry job queue fills.
// A stall on the result side holds the output register; the front keeps going.
// Reset is asynchronous and clears state at once; no clearing pass.
`default_nettype none

module rgb_led_shift_frame_controller (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] kind_i,
  input  wire logic [3:0] led_number_i,
  input  wire logic [3:0] color_i,
  input  wire logic       reverse_i,
  input  wire logic       comet_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            shift_valid_o,
  output logic            serial_data_o,
  output logic            latch_pulse_o,
  output logic            last_o,
  output logic [7:0]      pwm_compare_o,
  output logic            driver_enable_o,
  output logic            ir_led_o,
  output logic            swinger_o
);
  import rsfc_pkg::*;

  job_t    new_job, head_job;
  logic    accept;
  logic    job_empty, job_pop;
  logic    res_valid;
  result_t res;

  assign accept = push && !full;

  rsfc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .led_number_i (led_number_i),
    .color_i      (color_i),
    .reverse_i    (reverse_i),
    .comet_i      (comet_i),
    .job_o        (new_job)
  );

  rsfc_job_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (new_job),
    .full_o    (full),
    .rd_en_i   (job_pop),
    .rd_data_o (head_job),
    .empty_o   (job_empty)
  );

  rsfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_pop_i   (pop && res_valid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty           = !res_valid;
  assign shift_valid_o   = res.shift_valid;
  assign serial_data_o   = res.serial_data;
  assign latch_pulse_o   = res.latch_pulse;
  assign last_o          = res.last;
  assign pwm_compare_o   = res.pwm_compare;
  assign driver_enable_o = res.driver_enable;
  assign ir_led_o        = res.ir_led;
  assign swinger_o       = res.swinger;

endmodule

`default_nettype wire

// ===== design/rsfc_checker.sv =====
// Port-level checks for the RGB LED shift-frame controller, bound to the
// top level. Depends on rsfc_pkg and rgb_led_shift_frame_controller.
`default_nettype none

module rsfc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       shift_valid_o,
  input wire logic       serial_data_o,
  input wire logic       latch_pulse_o,
  input wire logic       last_o,
  input wire logic [7:0] pwm_compare_o,
  input wire logic       driver_enable_o
);
  import rsfc_pkg::*;

  // The latch comes only with the final shifted bit
  a_latch_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && latch_pulse_o) |-> (last_o && shift_valid_o))
    else $error("latch without final shifted bit");

  // A set or clear result is a single, bare item
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !shift_valid_o) |-> (last_o && !serial_data_o && !latch_pulse_o))
    else $error("non-shift result malformed");

  // The driver is off only while the PWM shows off
  a_driver_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !driver_enable_o) |-> (pwm_compare_o == PWM_OFF))
    else $error("driver off with PWM running");

  // A shift burst continues without a gap after each transfer
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && shift_valid_o && !last_o) |=> (!empty && shift_valid_o))
    else $error("shift burst interrupted");

  // Hold a result that was not taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(serial_data_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind rgb_led_shift_frame_controller rsfc_checker u_rsfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .shift_valid_o   (shift_valid_o),
  .serial_data_o   (serial_data_o),
  .latch_pulse_o   (latch_pulse_o),
  .last_o          (last_o),
  .pwm_compare_o   (pwm_compare_o),
  .driver_enable_o (driver_enable_o)
);

`default_nettype wire
